// ===== rtl/core/rti_pkg.sv =====
// rti_pkg: widths, pipeline word type and helpers for the ray / triangle unit
// no dependencies; imported by ray_triangle_intersect and its testbench
package rti_pkg;

    localparam int COORD_W   = 16;                 // vertex and ray coordinates
    localparam int FRAC_BITS = 8;                  // fraction bits of a coordinate
    localparam int DIFF_W    = COORD_W + 1;        // vertex differences
    localparam int CROSS_W   = 2 * DIFF_W + 1;     // cross product components
    localparam int DOT_W     = 56;                 // triple products with headroom
    localparam int EPS_W     = 16;
    localparam int NORM_W    = 34;
    localparam int DIST_W    = 32;
    localparam int DIV_BITS  = DIST_W - 1;         // quotient bits worked out
    localparam int REM_W     = DOT_W + DIV_BITS + 1;
    localparam int EPS_SHIFT = 3 * FRAC_BITS - 16; // epsilon against |det|
    localparam int IDX_W     = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [IDX_W-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [IDX_W-1:0] REG_EPSILON  = 3'd6;

    // one word in the divider chain
    typedef struct packed {
        logic                     valid;
        logic                     ok;
        logic                     sat;
        logic [REM_W-1:0]         rem;
        logic [DOT_W-1:0]         mag;
        logic [DIV_BITS-1:0]      q;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
    } div_word_t;

    // clamp a cross product component to the normal width
    function automatic logic signed [NORM_W-1:0] sat_norm(
        input logic signed [CROSS_W-1:0] x
    );
        logic signed [NORM_W-1:0] r;
        if (x[CROSS_W-1] != x[NORM_W-1])
        begin
            r = x[CROSS_W-1] ? {1'b1, {(NORM_W-1){1'b0}}} : {1'b0, {(NORM_W-1){1'b1}}};
        end
        else
        begin
            r = x[NORM_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/ray_triangle_intersect.sv =====
// ray_triangle_intersect: pipelined ray / triangle test with exact hit rule
// and a restoring divider for the distance; depends on rti_pkg
// an accepted word passes the registers of stages 1 to 6, the divider stages and the output register
// throughput: one triangle per cycle; the 31 divider stages, one quotient
// bit each, set the depth; a stall at the output freezes the whole pipe
// reset: rst_n clears valid bits and loads the ray registers
// (origin 0, direction 0,0,256, epsilon 7); no clearing pass
module ray_triangle_intersect (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rti_pkg::IDX_W-1:0]         cfg_index,
    input  logic [15:0]                       cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [9*rti_pkg::COORD_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // distance, normal_x, normal_y, normal_z, two zero bits
    output logic [135:0]                      m_axis_tdata,
    // hit
    output logic                              m_axis_tuser
);
    import rti_pkg::*;

    // ray registers
    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [COORD_W-1:0] dir_reg [3];
    logic [EPS_W-1:0]          eps_reg;

    // pipe advances unless the output word is held
    logic adv;
    logic out_valid_reg;
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready     = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= 16'sd256;
            eps_reg    <= 16'd7;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORIGIN_X: org_reg[0] <= cfg_data;
                REG_ORIGIN_Y: org_reg[1] <= cfg_data;
                REG_ORIGIN_Z: org_reg[2] <= cfg_data;
                REG_DIR_X:    dir_reg[0] <= cfg_data;
                REG_DIR_Y:    dir_reg[1] <= cfg_data;
                REG_DIR_Z:    dir_reg[2] <= cfg_data;
                REG_EPSILON:  eps_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    // stage 1: vertex differences
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] e1_reg [3];
    logic signed [DIFF_W-1:0] e2_reg [3];
    logic signed [DIFF_W-1:0] s_reg  [3];
    logic signed [DIFF_W-1:0] ba_reg [3];
    logic signed [DIFF_W-1:0] cb_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= s_axis_tvalid;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_diff
        logic signed [DIFF_W-1:0] pa, pb, pc, po;
        assign pa = DIFF_W'($signed(s_axis_tdata[k*COORD_W +: COORD_W]));
        assign pb = DIFF_W'($signed(s_axis_tdata[(3+k)*COORD_W +: COORD_W]));
        assign pc = DIFF_W'($signed(s_axis_tdata[(6+k)*COORD_W +: COORD_W]));
        assign po = DIFF_W'(org_reg[k]);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                e1_reg[k] <= pa - pb;
                e2_reg[k] <= pa - pc;
                s_reg[k]  <= pa - po;
                ba_reg[k] <= pb - pa;
                cb_reg[k] <= pc - pb;
            end
        end
    end

    // stage 2: cross products
    logic                      v2_reg;
    logic signed [CROSS_W-1:0] c1_reg [3];
    logic signed [CROSS_W-1:0] c2_reg [3];
    logic signed [CROSS_W-1:0] c3_reg [3];
    logic signed [CROSS_W-1:0] cn_reg [3];
    logic signed [DIFF_W-1:0]  s2_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_cross
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                c1_reg[k] <= e1_reg[K1] * e2_reg[K2] - e1_reg[K2] * e2_reg[K1];
                c2_reg[k] <= s_reg[K1] * e2_reg[K2] - s_reg[K2] * e2_reg[K1];
                c3_reg[k] <= e1_reg[K1] * s_reg[K2] - e1_reg[K2] * s_reg[K1];
                cn_reg[k] <= ba_reg[K1] * cb_reg[K2] - ba_reg[K2] * cb_reg[K1];
                s2_reg[k] <= s_reg[k];
            end
        end
    end

    // stage 3: dot product terms
    logic                      v3_reg;
    logic signed [DOT_W-1:0]   pd_reg [3];
    logic signed [DOT_W-1:0]   pt_reg [3];
    logic signed [DOT_W-1:0]   pu_reg [3];
    logic signed [DOT_W-1:0]   pv_reg [3];
    logic signed [NORM_W-1:0]  n3_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_prod
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pd_reg[k] <= DOT_W'(dir_reg[k] * c1_reg[k]);
                pt_reg[k] <= DOT_W'(s2_reg[k] * c1_reg[k]);
                pu_reg[k] <= DOT_W'(dir_reg[k] * c2_reg[k]);
                pv_reg[k] <= DOT_W'(dir_reg[k] * c3_reg[k]);
                n3_reg[k] <= sat_norm(cn_reg[k]);
            end
        end
    end

    // stage 4: triple products
    logic                     v4_reg;
    logic signed [DOT_W-1:0]  det_reg, tn_reg, un_reg, vn_reg;
    logic signed [NORM_W-1:0] n4_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_reg <= pd_reg[0] + pd_reg[1] + pd_reg[2];
            tn_reg  <= pt_reg[0] + pt_reg[1] + pt_reg[2];
            un_reg  <= pu_reg[0] + pu_reg[1] + pu_reg[2];
            vn_reg  <= pv_reg[0] + pv_reg[1] + pv_reg[2];
            n4_reg  <= n3_reg;
        end
    end

    // stage 5: fold the determinant sign into the numerators
    logic                     v5_reg;
    logic                     zero5_reg;
    logic signed [DOT_W-1:0]  mag_reg, tf_reg, uf_reg, vf_reg;
    logic signed [NORM_W-1:0] n5_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero5_reg <= (det_reg == '0);
            mag_reg   <= det_reg[DOT_W-1] ? -det_reg : det_reg;
            tf_reg    <= det_reg[DOT_W-1] ? -tn_reg  : tn_reg;
            uf_reg    <= det_reg[DOT_W-1] ? -un_reg  : un_reg;
            vf_reg    <= det_reg[DOT_W-1] ? -vn_reg  : vn_reg;
            n5_reg    <= n4_reg;
        end
    end

    // stage 6: hit rule and divider set-up
    div_word_t div_reg  [DIV_BITS+1];
    div_word_t div_next [DIV_BITS+1];

    always_comb
    begin
        logic signed [DOT_W+1:0] uv_sum;
        logic [REM_W-1:0]        num;
        logic [REM_W-1:0]        mag_top;
        logic                    eps_ok;
        uv_sum  = (DOT_W+2)'(uf_reg) + (DOT_W+2)'(vf_reg);
        num     = REM_W'(tf_reg[DOT_W-1:0]) << 16;
        mag_top = REM_W'(mag_reg[DOT_W-1:0]) << DIV_BITS;
        eps_ok  = ((DOT_W+16)'(eps_reg) << EPS_SHIFT) <= (DOT_W+16)'(mag_reg[DOT_W-1:0]);
        div_next[0].valid = v5_reg;
        div_next[0].ok    = !zero5_reg && eps_ok && !uf_reg[DOT_W-1] && !vf_reg[DOT_W-1]
                            && (uv_sum <= (DOT_W+2)'(mag_reg))
                            && !tf_reg[DOT_W-1] && (tf_reg != '0);
        div_next[0].sat   = mag_top <= num;
        div_next[0].rem   = num;
        div_next[0].mag   = mag_reg[DOT_W-1:0];
        div_next[0].q     = '0;
        div_next[0].nx    = n5_reg[0];
        div_next[0].ny    = n5_reg[1];
        div_next[0].nz    = n5_reg[2];
    end

    // divider chain: one quotient bit a stage, top bit first
    for (genvar j = 1; j <= DIV_BITS; j++)
    begin : g_div
        localparam int B = DIV_BITS - j;
        logic [REM_W-1:0] shifted;
        logic             take;
        assign shifted = REM_W'(div_reg[j-1].mag) << B;
        assign take    = shifted <= div_reg[j-1].rem;
        always_comb
        begin
            div_next[j] = div_reg[j-1];
            if (take)
            begin
                div_next[j].rem  = div_reg[j-1].rem - shifted;
                div_next[j].q[B] = 1'b1;
            end
        end
    end

    for (genvar j = 0; j <= DIV_BITS; j++)
    begin : g_div_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_reg[j].valid <= 1'b0;
            else if (adv)
                div_reg[j] <= div_next[j];
        end
    end

    // output word: clamp distance, compare with epsilon, zero on miss
    logic                     hit_reg;
    logic signed [DIST_W-1:0] dist_reg;
    logic signed [NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic [DIST_W-1:0]        q_fin;
    logic                     hit_fin;

    assign q_fin   = div_reg[DIV_BITS].sat ? {1'b0, {DIV_BITS{1'b1}}}
                                           : {1'b0, div_reg[DIV_BITS].q};
    assign hit_fin = div_reg[DIV_BITS].ok && (q_fin > DIST_W'(eps_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div_reg[DIV_BITS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg  <= hit_fin;
            dist_reg <= hit_fin ? q_fin : '0;
            nx_reg   <= hit_fin ? div_reg[DIV_BITS].nx : '0;
            ny_reg   <= hit_fin ? div_reg[DIV_BITS].ny : '0;
            nz_reg   <= hit_fin ? div_reg[DIV_BITS].nz : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = hit_reg;
    assign m_axis_tdata  = {2'b00, nz_reg, ny_reg, nx_reg, dist_reg};

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hit_reg |-> dist_reg == '0 && nx_reg == '0
                                      && ny_reg == '0 && nz_reg == '0)
        else $error("miss word with non-zero fields");

    // a hit lies beyond epsilon and is non-negative
    a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hit_reg |-> !dist_reg[DIST_W-1]
                                     && dist_reg > DIST_W'(eps_reg))
        else $error("hit distance not beyond epsilon");

    // a held output freezes the pipe valid bits
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v1_reg) && $stable(v5_reg) && $stable(div_reg[DIV_BITS].valid))
        else $error("pipe moved during a stall");

    // a saturated quotient never reports a smaller distance
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        adv && div_reg[DIV_BITS].valid && div_reg[DIV_BITS].sat && hit_fin
        |=> dist_reg == {1'b0, {DIV_BITS{1'b1}}})
        else $error("saturated distance lost");

endmodule

// ===== tb/tb_ray_triangle_intersect.sv =====
// testbench for ray_triangle_intersect: streams triangles against several ray settings
// and checks every result word against an exact fixed-point Moller-Trumbore predictor
// depends on rti_pkg and ray_triangle_intersect
`timescale 1ns / 100ps

module tb_ray_triangle_intersect;

    import rti_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;   // beyond the register list
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 60;                  // pipe depth plus margin
    localparam int HOLD_OFF    = 400;

    typedef logic signed [127:0] wide_t;
    typedef logic [9*COORD_W-1:0] tri_t;
    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        logic [NORM_W-1:0] nz;
    } hit_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [IDX_W-1:0]          cfg_index;
    logic [15:0]               cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    logic [9*COORD_W-1:0]      s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // distance, normal_x, normal_y, normal_z, two zero bits
    logic [135:0]              m_axis_tdata;
    // hit
    logic                      m_axis_tuser;

    // shadow copy of the ray registers
    logic signed [15:0] ray_org [3];
    logic signed [15:0] ray_dir [3];
    logic [15:0]        ray_eps;

    hit_result_t pending_hits [$];
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int errors;
    int n_sent;
    int n_results;
    int n_hits;
    int stall_cycles;

    ray_triangle_intersect DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic wide_t vtx(tri_t t, int i, int k);
        return wide_t'($signed(t[COORD_W*(3*i+k) +: COORD_W]));
    endfunction

    function automatic void cross3(input wide_t a0, a1, a2, b0, b1, b2,
                                   output wide_t r0, r1, r2);
        r0 = a1 * b2 - a2 * b1;
        r1 = a2 * b0 - a0 * b2;
        r2 = a0 * b1 - a1 * b0;
    endfunction

    function automatic logic [NORM_W-1:0] clamp_normal(wide_t x);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (NORM_W - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
            x = hi;
        if (x < lo)
            x = lo;
        return x[NORM_W-1:0];
    endfunction

    // exact intersection test with the current ray
    function automatic hit_result_t intersect_ray(tri_t t);
        wide_t e1 [3];
        wide_t e2 [3];
        wide_t sv [3];
        wide_t ba [3];
        wide_t cb [3];
        wide_t d [3];
        wide_t c0, c1, c2;
        wide_t det, tn, un, vn, mag, q, epsw;
        hit_result_t r;
        r = '0;
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = vtx(t, 0, k) - vtx(t, 1, k);
            e2[k] = vtx(t, 0, k) - vtx(t, 2, k);
            sv[k] = vtx(t, 0, k) - wide_t'(ray_org[k]);
            ba[k] = vtx(t, 1, k) - vtx(t, 0, k);
            cb[k] = vtx(t, 2, k) - vtx(t, 1, k);
            d[k]  = wide_t'(ray_dir[k]);
        end
        cross3(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], c0, c1, c2);
        det = d[0] * c0 + d[1] * c1 + d[2] * c2;
        tn  = sv[0] * c0 + sv[1] * c1 + sv[2] * c2;
        cross3(sv[0], sv[1], sv[2], e2[0], e2[1], e2[2], c0, c1, c2);
        un = d[0] * c0 + d[1] * c1 + d[2] * c2;
        cross3(e1[0], e1[1], e1[2], sv[0], sv[1], sv[2], c0, c1, c2);
        vn = d[0] * c0 + d[1] * c1 + d[2] * c2;
        if (det == 0)
            return r;
        mag = det;
        if (det < 0)
        begin
            mag = -det;
            tn  = -tn;
            un  = -un;
            vn  = -vn;
        end
        epsw = wide_t'({112'd0, ray_eps});
        // |det| against epsilon: det carries 24 fraction bits, epsilon 16
        if ((epsw <<< 8) > mag)
            return r;
        if (un < 0 || vn < 0 || mag < un + vn)
            return r;
        if (tn <= 0)
            return r;
        q = (tn <<< 16) / mag;
        if (q > 128'sh7FFF_FFFF)
            q = 128'sh7FFF_FFFF;
        if (q <= epsw)
            return r;
        cross3(ba[0], ba[1], ba[2], cb[0], cb[1], cb[2], c0, c1, c2);
        r.hit      = 1'b1;
        r.distance = q[DIST_W-1:0];
        r.nx       = clamp_normal(c0);
        r.ny       = clamp_normal(c1);
        r.nz       = clamp_normal(c2);
        return r;
    endfunction

    function automatic tri_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
        return {cz[15:0], cy[15:0], cx[15:0], bz[15:0], by[15:0], bx[15:0],
                az[15:0], ay[15:0], ax[15:0]};
    endfunction

    // triangle scattered around a point on the ray, or pure noise
    function automatic tri_t random_tri(bit near_ray);
        tri_t t;
        int centre [3];
        int k, span;
        t = tri_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if (!near_ray)
            return t;
        k = $urandom_range(1024);
        span = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(1, 3000);
        for (int i = 0; i < 3; i++)
            centre[i] = int'(ray_org[i]) + ((int'(ray_dir[i]) * k) >>> 8);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                t[COORD_W*(3*i+j) +: COORD_W] =
                    16'(centre[j] + $urandom_range(2 * span) - span);
        return t;
    endfunction

    // one triangle word, with random gaps before it
    task automatic send_tri(tri_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_hits.insert(pending_hits.size(), intersect_ray(t));
        n_sent++;
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        end_burst();
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // write every ray register, plus the unused index, then drop valid
    task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz, int eps);
        logic [15:0] vals [8];
        vals = '{ox[15:0], oy[15:0], oz[15:0], dx[15:0], dy[15:0], dz[15:0], eps[15:0],
                 16'h5A5A};
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (IDX_W'(i))
                REG_ORIGIN_X: ray_org[0] = vals[i];
                REG_ORIGIN_Y: ray_org[1] = vals[i];
                REG_ORIGIN_Z: ray_org[2] = vals[i];
                REG_DIR_X:    ray_dir[0] = vals[i];
                REG_DIR_Y:    ray_dir[1] = vals[i];
                REG_DIR_Z:    ray_dir[2] = vals[i];
                REG_EPSILON:  ray_eps    = vals[i];
                REG_UNUSED:   ;
                default:      ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // reset values of the ray, then special triangles
    task automatic test_directed_default();
        send_tri(make_tri(-256, -256, 256, 512, -256, 256, -256, 512, 256));  // hit
        send_tri(make_tri(-256, -256, 256, -256, 512, 256, 512, -256, 256));  // other winding
        send_tri(make_tri(-256, -256, -256, 512, -256, -256, -256, 512, -256)); // behind
        send_tri(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768));                          // degenerate
        send_tri(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767));
        send_tri(make_tri(0, -256, 0, 0, 256, 256, 0, -256, 512));            // edge-on
        send_tri(make_tri(0, 0, 256, 256, 0, 256, 0, 256, 256));              // ray at vertex
        send_tri(make_tri(256, 256, 256, 512, 256, 256, 256, 512, 256));      // outside
        send_tri(make_tri(-256, -256, 1, 512, -256, 1, -256, 512, 1));        // very close
        send_tri(make_tri(-256, -256, 0, 512, -256, 0, -256, 512, 0));        // at origin
        send_tri(make_tri(-32768, -32768, 32767, 32767, -32768, -32768,
                          -32768, 32767, 0));                                 // huge normal
        send_tri(make_tri(32767, -32768, 100, -32768, 32767, 100,
                          -32768, -32768, 100));
        wait_drained();
    endtask

    // register extremes: saturated distance, epsilon limits, far origin
    task automatic test_directed_extremes();
        set_ray(0, 0, 0, 0, 0, 1, 0);
        send_tri(make_tri(-256, -256, 32767, 512, -256, 32767, -256, 512, 32767));
        send_tri(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768));
        send_tri(make_tri(-256, -256, 1, 512, -256, 1, -256, 512, 1));
        wait_drained();
        set_ray(0, 0, 0, 0, 0, 256, 65535);
        send_tri(make_tri(-256, -256, 256, 512, -256, 256, -256, 512, 256));
        send_tri(make_tri(-256, -256, 255, 512, -256, 255, -256, 512, 255));
        send_tri(make_tri(-256, -256, 2560, 512, -256, 2560, -256, 512, 2560));
        wait_drained();
        set_ray(-32768, -32768, -32768, 32767, 32767, 32767, 7);
        send_tri(make_tri(0, 0, 0, 32767, -32768, 0, -32768, 32767, 0));
        send_tri(make_tri(-32768, -32768, 32767, 32767, 32767, -32768, 0, 0, 0));
        wait_drained();
        set_ray(32767, 32767, 32767, -32768, -32768, -32768, 65535);
        send_tri(make_tri(0, 0, 0, 32767, -32768, 0, -32768, 32767, 0));
        wait_drained();
    endtask

    // random triangles, mostly near the ray, under one idling mix
    task automatic test_random(int n, int sp, int rp);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        for (int i = 0; i < n; i++)
            send_tri(random_tri($urandom_range(99) < 80));
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = HOLD_OFF;
        for (int i = 0; i < 70; i++)
            send_tri(random_tri(1'b1));
        wait_drained();
    endtask

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        hit_result_t want;
        hit_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.hit      = m_axis_tuser;
            got.distance = m_axis_tdata[31:0];
            got.nx       = m_axis_tdata[65:32];
            got.ny       = m_axis_tdata[99:66];
            got.nz       = m_axis_tdata[133:100];
            n_results++;
            if (pending_hits.size() == 0)
            begin
                $display("%0t: result word with nothing expected: %p", $time, got);
                errors++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (got.hit)
                    n_hits++;
                if (got.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
                    errors++;
                end
                if (got.distance !== want.distance)
                begin
                    $display("%0t: distance expected %h actual %h", $time, want.distance,
                             got.distance);
                    errors++;
                end
                if (got.nx !== want.nx)
                begin
                    $display("%0t: normal_x expected %h actual %h", $time, want.nx, got.nx);
                    errors++;
                end
                if (got.ny !== want.ny)
                begin
                    $display("%0t: normal_y expected %h actual %h", $time, want.ny, got.ny);
                    errors++;
                end
                if (got.nz !== want.nz)
                begin
                    $display("%0t: normal_z expected %h actual %h", $time, want.nz, got.nz);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // test sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 0;
        errors = 0;
        n_sent = 0;
        n_results = 0;
        n_hits = 0;
        stall_cycles = 0;
        ray_org = '{16'sd0, 16'sd0, 16'sd0};
        ray_dir = '{16'sd0, 16'sd0, 16'sd256};
        ray_eps = 16'd7;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_default();
        test_directed_extremes();
        set_ray(128, -300, -1024, 40, -25, 300, 7);
        test_random(130, 33, 86);
        set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(200));
        test_random(130, 86, 33);
        set_ray(-2000, 1500, 0, -90, 60, 512, 0);
        test_random(130, 0, 0);
        test_backpressure();

        $display("%0d triangles over eight ray settings, %0d results, %0d hits",
                 n_sent, n_results, n_hits);
        $display("covered reset ray, register extremes, stalls on both sides and a full pipe");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== ray_triangle_intersect.f =====
rtl/core/rti_pkg.sv
rtl/core/ray_triangle_intersect.sv
tb/tb_ray_triangle_intersect.sv
